/* rtl/base64_stream_encoder_top_macros.svh */
// Assertion helpers for the Base64 stream encoder.
// Each macro expects clk_i and rst_ni in scope.
`ifndef BASE64_STREAM_ENCODER_TOP_MACROS_SVH
`define BASE64_STREAM_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B64E_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define B64E_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/b64e_pkg.sv */
package b64e_pkg;

  // Command codes of an input beat
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Characters
  localparam logic [7:0] CHAR_NL   = 8'h0A;
  localparam logic [7:0] CHAR_PAD  = 8'h3D;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_SLSH = 8'h2F;

  // Register indexes
  localparam logic REG_STRIP_NEWLINES = 1'b0;

  // Defaults for top-level parameters
  localparam int LINE_WRAP_DEF  = 72;
  localparam int FIFO_DEPTH_DEF = 2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  // One unit of work for the back end: a group and/or a message end
  typedef struct packed {
    logic       is_end;
    logic [1:0] count;   // bytes in the group, 0 only for an empty end
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Map a sextet to its alphabet symbol
  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      r = CHAR_PLUS;
    end else begin
      r = CHAR_SLSH;
    end
    return r;
  endfunction

endpackage

/* rtl/b64e_front.sv */
module b64e_front import b64e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  input  fifo_stat_t stat_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [15:0] held_q, held_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        accept;

  assign in_stall_o = stat_i.full;
  assign accept     = in_valid_i && !stat_i.full;

  // Classify the beat: a third byte or an end both hand a job to the back end
  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    push_o = 1'b0;
    job_o  = '0;
    if (in_item_i.cmd == CMD_END) begin
      job_o.is_end = 1'b1;
      job_o.count  = cnt_q;
      job_o.b0     = held_q[15:8];
      job_o.b1     = (cnt_q == 2'd2) ? held_q[7:0] : 8'h00;
      job_o.b2     = 8'h00;
      push_o       = accept;
      if (accept) begin
        held_d = '0;
        cnt_d  = '0;
      end
    end else begin
      job_o.is_end = 1'b0;
      job_o.count  = 2'd3;
      job_o.b0     = held_q[15:8];
      job_o.b1     = held_q[7:0];
      job_o.b2     = in_item_i.in_byte;
      if (cnt_q == 2'd2) begin
        push_o = accept;
        if (accept) begin
          held_d = '0;
          cnt_d  = '0;
        end
      end else if (accept) begin
        if (cnt_q == 2'd1) begin
          held_d = {held_q[15:8], in_item_i.in_byte};
          cnt_d  = 2'd2;
        end else begin
          held_d = {in_item_i.in_byte, 8'h00};
          cnt_d  = 2'd1;
        end
      end
    end
  end

  // Hold partial group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* rtl/b64e_fifo.sv */
module b64e_fifo import b64e_pkg::*; #(
  parameter int Depth = FIFO_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  job_t       job_i,
  input  logic       pop_i,
  output job_t       job_o,
  output fifo_stat_t stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = mem_q[rptr_q];

  // Store entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* rtl/b64e_back.sv */
module b64e_back import b64e_pkg::*; #(
  parameter int LineWrap = LINE_WRAP_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       strip_i,
  input  fifo_stat_t stat_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  localparam int PosW = $clog2(LineWrap + 1);

  // Sequencer steps: four group characters, then the final newline
  localparam logic [2:0] IDX_FINAL = 3'd4;
  localparam logic [2:0] IDX_DONE  = 3'd5;
  localparam logic [2:0] MAX_OUT   = 3'd6;

  job_t            job_q;
  logic            busy_q;
  logic [2:0]      idx_q, idx_d;
  logic            nl_q, nl_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [PosW-1:0] pos_q, pos_d, pos_inc;
  logic            oval_q;
  out_item_t       oitem_q;

  logic            adv, emit_any, more, step;
  logic [5:0]      sextet;
  logic [7:0]      ch;

  assign adv      = !oval_q || !out_stall_i;
  assign pop_o    = !busy_q && !stat_i.empty;
  assign emit_any = nl_q || (idx_q < IDX_FINAL) ||
                    ((idx_q == IDX_FINAL) && job_q.is_end && !strip_i);
  assign step     = busy_q && emit_any && adv;
  assign pos_inc  = pos_q + PosW'(1);

  // Pick the sextet for the current group position
  always_comb begin
    unique case (idx_q[1:0])
      2'd0:    sextet = job_q.b0[7:2];
      2'd1:    sextet = {job_q.b0[1:0], job_q.b1[7:4]};
      2'd2:    sextet = {job_q.b1[3:0], job_q.b2[7:6]};
      default: sextet = job_q.b2[5:0];
    endcase
  end

  // Work out this character and the step after it
  always_comb begin
    idx_d = idx_q;
    nl_d  = nl_q;
    pos_d = pos_q;
    ch    = CHAR_NL;
    if (nl_q) begin
      nl_d  = 1'b0;
      pos_d = PosW'(1);
    end else if (idx_q < IDX_FINAL) begin
      if ((idx_q == 3'd3 && job_q.count != 2'd3) ||
          (idx_q == 3'd2 && job_q.count == 2'd1)) begin
        ch = CHAR_PAD;
      end else begin
        ch = b64_symbol(sextet);
      end
      idx_d = idx_q + 3'd1;
      if (pos_inc >= PosW'(LineWrap)) begin
        pos_d = '0;
        nl_d  = !strip_i;
      end else begin
        pos_d = pos_inc;
      end
    end else begin
      idx_d = IDX_DONE;
    end
    cnt_d = cnt_q + 3'd1;
    more  = (cnt_d < MAX_OUT) &&
            (nl_d || (idx_d < IDX_FINAL) ||
             ((idx_d == IDX_FINAL) && job_q.is_end && !strip_i));
  end

  // Run the job sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      nl_q   <= 1'b0;
      cnt_q  <= '0;
      pos_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= (!job_i.is_end || job_i.count != 2'd0) ? 3'd0 : IDX_FINAL;
      nl_q   <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q && !emit_any) begin
      // empty end with newlines stripped: nothing to send
      busy_q <= 1'b0;
      if (job_q.is_end) begin
        pos_q <= '0;
      end
    end else if (step) begin
      idx_q <= idx_d;
      nl_q  <= nl_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      if (!more) begin
        busy_q <= 1'b0;
        if (job_q.is_end) begin
          pos_q <= '0;
        end
      end
    end
  end

  // Latch job
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  // Output register: load a character or drop a taken beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (adv) begin
      oval_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      oitem_q.out_char <= ch;
      oitem_q.last     <= !more;
    end
  end

  assign out_valid_o = oval_q;
  assign out_item_o  = oitem_q;

endmodule

/* rtl/base64_stream_encoder_top.sv */
// Base64 stream encoder with optional line wrapping.
// Path: a group or end beat goes through the job queue, the back end's job latch and the
//   output register before its first character. Throughput: one character per cycle from
//   the sequencer unless stalled, with a load step between jobs; a two-entry job queue feeds it.
// Reset: rst_ni is asynchronous, active low; it empties the queue, clears the held bytes,
//   line position and output valid flag, and sets strip_newlines to 0.
`include "base64_stream_encoder_top_macros.svh"

module base64_stream_encoder_top import b64e_pkg::*; #(
  parameter int LineWrap  = LINE_WRAP_DEF,
  parameter int FifoDepth = FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  // output beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       strip_q;
  logic       push, pop;
  job_t       push_job, pop_job;
  fifo_stat_t stat;
  logic       out_is_nl;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_STRIP_NEWLINES) ? {31'b0, strip_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_STRIP_NEWLINES) begin
      strip_q <= pwdata[0];
    end
  end

  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .stat_i     (stat),
    .push_o     (push),
    .job_o      (push_job)
  );

  b64e_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (pop_job),
    .stat_o (stat)
  );

  b64e_back #(
    .LineWrap (LineWrap)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .strip_i     (strip_q),
    .stat_i      (stat),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  assign out_is_nl = (out_item_o.out_char == CHAR_NL);

  `B64E_ASSERT_IMP(a_push_not_full, push, !stat.full, "job pushed into full queue")
  `B64E_ASSERT_IMP(a_pop_not_empty, pop, !stat.empty, "job popped from empty queue")
  `B64E_ASSERT_NXT(a_push_fills, push && stat.empty, !stat.empty, "pushed job lost")
  `B64E_ASSERT_IMP(a_no_nl_stripped, out_valid_o && strip_q, !out_is_nl, "newline while stripped")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import b64e_pkg::*;

  localparam int         IDLE_GAP       = 10;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         MAX_PER_BEAT   = 6;
  localparam logic [2:0] STRIP_ADDR     = {REG_STRIP_NEWLINES, 2'b00};
  localparam logic [2:0] UNUSED_ADDR    = {~REG_STRIP_NEWLINES, 2'b00};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // Encoder state as seen by the predictor
  logic        strip_q      = 1'b0;
  logic [15:0] held_bytes_q = '0;
  int          held_cnt     = 0;
  int          line_pos     = 0;
  int          beat_chars   = 0;
  out_item_t   pending_chars[$];

  int fail_cnt      = 0;
  int idle_cycles   = 0;
  int snd_idle_pct  = 8;
  int rcv_stall_pct = 62;

  base64_stream_encoder_top u_top (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Map a 6-bit value to its character: A-Z, a-z, 0-9, then plus and slash
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v) - 8'd26;
    if (v < 6'd62) return 8'h30 + 8'(v) - 8'd52;
    return (v == 6'd62) ? CHAR_PLUS : CHAR_SLSH;
  endfunction

  // Queue one character, dropping anything past the per-beat cap
  function automatic void push_char(input logic [7:0] ch);
    if (beat_chars < MAX_PER_BEAT) begin
      pending_chars.push_back('{out_char: ch, last: 1'b0});
      beat_chars++;
    end
  endfunction

  // Emit a character and advance the line position, wrapping when it fills
  function automatic void put_char(input logic [7:0] ch);
    push_char(ch);
    line_pos++;
    if (line_pos >= LINE_WRAP_DEF) begin
      line_pos = 0;
      if (!strip_q) begin
        push_char(CHAR_NL);
        line_pos = 1;
      end
    end
  endfunction

  // Emit four characters for a group of n_bytes, padding the missing tail
  function automatic void put_group(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input int n_bytes);
    logic [23:0] grp;
    grp = {b0, b1, b2};
    for (int i = 0; i < 4; i++) begin
      logic [7:0] ch;
      ch = sextet_char(grp[23 - 6 * i -: 6]);
      if (i > n_bytes) ch = CHAR_PAD;
      put_char(ch);
    end
  endfunction

  // Work out the characters one accepted input beat produces
  function automatic void encode_beat(input in_item_t item);
    beat_chars = 0;
    if (item.cmd == CMD_DATA) begin
      if (held_cnt == 2) begin
        put_group(held_bytes_q[15:8], held_bytes_q[7:0], item.in_byte, 3);
        held_bytes_q = '0;
        held_cnt     = 0;
      end else if (held_cnt == 1) begin
        held_bytes_q[7:0] = item.in_byte;
        held_cnt          = 2;
      end else begin
        held_bytes_q = {item.in_byte, 8'h00};
        held_cnt     = 1;
      end
    end else begin
      if (held_cnt > 0) begin
        put_group(held_bytes_q[15:8], (held_cnt == 2) ? held_bytes_q[7:0] : 8'h00,
                  8'h00, held_cnt);
      end
      if (!strip_q) push_char(CHAR_NL);
      held_bytes_q = '0;
      held_cnt     = 0;
      line_pos     = 0;
    end
    if (beat_chars > 0) pending_chars[pending_chars.size() - 1].last = 1'b1;
  endfunction

  // Check each output beat, drive receiver stalls, watch for a hang
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: out_char %h last %b",
               out_item_o.out_char, out_item_o.last);
        fail_cnt++;
      end else begin
        want = pending_chars.pop_front();
        if (out_item_o.out_char !== want.out_char) begin
          $error("out_char: expected %h, got %h", want.out_char, out_item_o.out_char);
          fail_cnt++;
        end
        if (out_item_o.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_item_o.last);
          fail_cnt++;
        end
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** base64_stream_encoder_top: FAILED **");
      $finish;
    end
    out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
  end

  // Send one input beat, idling at random first, and predict its output
  task automatic send_beat(input logic cmd, input logic [7:0] data);
    in_item_t item;
    item.cmd     = cmd;
    item.in_byte = data;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    encode_beat(item);
  endtask

  // Hold the input until every character is out, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  // Write the strip register (or a dead address) while idle, then read it back
  task automatic config_strip(input logic [2:0] addr, input logic val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {31'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == STRIP_ADDR) strip_q = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= STRIP_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== strip_q) begin
      $error("strip_newlines: expected %b, got %b", strip_q, prdata[0]);
      fail_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_message(input int n_bytes);
    for (int i = 0; i < n_bytes; i++) send_beat(CMD_DATA, 8'($urandom));
    send_beat(CMD_END, 8'($urandom));
  endtask

  // Full groups: all zero, all ones, and the plus and slash symbols
  task automatic test_groups();
    config_strip(STRIP_ADDR, 1'b0);
    send_beat(CMD_DATA, 8'h00);
    send_beat(CMD_DATA, 8'h00);
    send_beat(CMD_DATA, 8'h00);
    send_beat(CMD_DATA, 8'hFF);
    send_beat(CMD_DATA, 8'hFF);
    send_beat(CMD_DATA, 8'hFF);
    send_beat(CMD_DATA, 8'hFB);
    send_beat(CMD_DATA, 8'hEF);
    send_beat(CMD_DATA, 8'hBE);
    send_beat(CMD_END, 8'hFF);
  endtask

  // Partial groups with one and two pad characters, and an empty message
  task automatic test_padding();
    send_beat(CMD_DATA, 8'h4D);
    send_beat(CMD_END, 8'h00);
    send_beat(CMD_DATA, 8'h4D);
    send_beat(CMD_DATA, 8'h61);
    send_beat(CMD_END, 8'h55);
    send_beat(CMD_END, 8'hAA);
  endtask

  // Dead address, stripped output, and a register change mid-message
  task automatic test_strip();
    config_strip(UNUSED_ADDR, 1'b1);
    config_strip(STRIP_ADDR, 1'b1);
    send_beat(CMD_END, 8'h00);
    send_beat(CMD_DATA, 8'hFF);
    send_beat(CMD_END, 8'hFF);
    send_beat(CMD_DATA, 8'h80);
    send_beat(CMD_DATA, 8'h01);
    config_strip(STRIP_ADDR, 1'b0);
    send_beat(CMD_END, 8'h7F);
  endtask

  // A wrapped line, then counting on through a stripped stretch into a wrap
  task automatic test_line_wrap();
    config_strip(STRIP_ADDR, 1'b0);
    send_message(56);
    config_strip(STRIP_ADDR, 1'b1);
    for (int i = 0; i < 24; i++) send_beat(CMD_DATA, 8'($urandom));
    config_strip(STRIP_ADDR, 1'b0);
    send_message(30);
  endtask

  // Random messages: mostly short, some long enough to wrap
  task automatic test_random(input int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(99) < 80) ? $urandom_range(8) : $urandom_range(60, 40);
      send_message(len);
      sent += len + 1;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender mostly busy, receiver stalling often
    snd_idle_pct  = 8;
    rcv_stall_pct = 62;
    test_groups();
    test_padding();
    test_strip();
    test_random(12);

    // Sender idling often, receiver mostly ready
    config_strip(STRIP_ADDR, 1'b1);
    snd_idle_pct  = 62;
    rcv_stall_pct = 8;
    test_random(12);
    test_line_wrap();

    // No idling on either side
    config_strip(STRIP_ADDR, 1'b0);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    test_random(12);
    config_strip(STRIP_ADDR, 1'b1);
    test_random(12);

    drain();
    if (fail_cnt == 0) begin
      $display("** base64_stream_encoder_top: PASSED **");
    end else begin
      $display("** base64_stream_encoder_top: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_fifo.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder_top.sv
dv/testbench.sv
